### sv/utf8d_pkg.sv
// utf8d_pkg: shared types and constants for the UTF-8 stream decoder.
// No dependencies; used by utf8d_rsp_if, utf8d_step and the top level.
package utf8d_pkg;

   localparam int MaxSeqBytes = 4;
   localparam int CpWidth     = 21;

   typedef enum logic [2:0] {
      ERR_OK     = 3'd0,
      ERR_STRAY  = 3'd1,
      ERR_FOLLOW = 3'd2,
      ERR_LONG   = 3'd3,
      ERR_TRUNC  = 3'd4
   } err_type;

   typedef struct packed {
      logic                has_result;
      logic [CpWidth-1:0]  code_point;
      err_type             error_code;
      logic [CpWidth-1:0]  partial_in;
      logic [1:0]          pending_in;
   } step_type;

endpackage

### sv/utf8d_if.sv
// utf8d_req_if / utf8d_rsp_if: valid/ready channels for byte requests and decode results.
// utf8d_rsp_if depends on utf8d_pkg; utf8d_req_if has no dependencies.
interface utf8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface utf8d_rsp_if
   import utf8d_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [CpWidth-1:0] code_point;
   logic [2:0]         error_code;

   modport source (output valid, output code_point, output error_code, input ready);
   modport sink   (input valid, input code_point, input error_code, output ready);
endinterface

### sv/utf8d_step.sv
// utf8d_step: one decode step, byte plus current state to result and next state.
// Purely combinational; depends on utf8d_pkg.
module utf8d_step
   import utf8d_pkg::*;
(
   input  logic [7:0]         data_byte,
   input  logic               stream_end,
   input  logic [CpWidth-1:0] partial_ff,
   input  logic [1:0]         pending_ff,
   output step_type           step
);

   logic [CpWidth-1:0] merged;

   assign merged = {partial_ff[CpWidth-7:0], data_byte[5:0]};

   always_comb begin
      step            = '0;
      step.error_code = ERR_OK;
      step.partial_in = partial_ff;
      step.pending_in = pending_ff;
      if (pending_ff == 2'd0) begin
         if (!stream_end) begin
            case (data_byte) inside
               8'b0???????: begin
                  step.has_result = 1'b1;
                  step.code_point = CpWidth'(data_byte);
               end
               8'b10??????: begin
                  step.has_result = 1'b1;
                  step.error_code = ERR_STRAY;
                  step.partial_in = '0;
               end
               8'b110?????: begin
                  step.partial_in = CpWidth'(data_byte[4:0]);
                  step.pending_in = 2'd1;
               end
               8'b1110????: begin
                  if (MaxSeqBytes >= 3) begin
                     step.partial_in = CpWidth'(data_byte[3:0]);
                     step.pending_in = 2'd2;
                  end else begin
                     step.has_result = 1'b1;
                     step.error_code = ERR_LONG;
                     step.partial_in = '0;
                  end
               end
               8'b11110???: begin
                  if (MaxSeqBytes >= 4) begin
                     step.partial_in = CpWidth'(data_byte[2:0]);
                     step.pending_in = 2'd3;
                  end else begin
                     step.has_result = 1'b1;
                     step.error_code = ERR_LONG;
                     step.partial_in = '0;
                  end
               end
               default: begin
                  step.has_result = 1'b1;
                  step.error_code = ERR_LONG;
                  step.partial_in = '0;
               end
            endcase
         end
      end else if (stream_end) begin
         step.has_result = 1'b1;
         step.error_code = ERR_TRUNC;
         step.partial_in = '0;
         step.pending_in = 2'd0;
      end else if (data_byte[7:6] != 2'b10) begin
         step.has_result = 1'b1;
         step.error_code = ERR_FOLLOW;
         step.partial_in = '0;
         step.pending_in = 2'd0;
      end else begin
         step.pending_in = pending_ff - 2'd1;
         if (pending_ff == 2'd1) begin
            step.has_result = 1'b1;
            step.code_point = merged;
            step.partial_in = '0;
         end else begin
            step.partial_in = merged;
         end
      end
   end

endmodule

### sv/utf8_stream_decoder_top.sv
// utf8_stream_decoder_top: byte-serial UTF-8 decoder, input register, step logic, result register.
// Depends on utf8d_pkg, utf8d_req_if, utf8d_rsp_if and utf8d_step.
//
//   channel   dir  payload                         note
//   req_bus   in   data_byte[7:0], stream_end      one request per byte
//   rsp_bus   out  code_point[20:0], error_code    zero or one per request
//
// One request per cycle while results are taken; a request passes the input register, then
// the step logic into the result register. The decode state (partial value, pending count)
// updates with each step. Reset is synchronous and clears valids and decode state.
// A stalled result holds the step stage; requests stall only when both fill.
module utf8_stream_decoder_top
   import utf8d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   utf8d_req_if.sink   req_bus,
   utf8d_rsp_if.source rsp_bus
);

   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               in_end_ff;
   logic [CpWidth-1:0] partial_ff;
   logic [1:0]         pending_ff;
   logic               out_valid_ff;
   logic [CpWidth-1:0] out_cp_ff;
   err_type            out_err_ff;
   logic               out_free;
   logic               step_fire;
   step_type           step;

   utf8d_step u_step (
      .data_byte  (in_byte_ff),
      .stream_end (in_end_ff),
      .partial_ff (partial_ff),
      .pending_ff (pending_ff),
      .step       (step)
   );

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign step_fire     = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         partial_ff   <= '0;
         pending_ff   <= 2'd0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (step_fire) begin
            partial_ff   <= step.partial_in;
            pending_ff   <= step.pending_in;
            out_valid_ff <= step.has_result;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff <= req_bus.data_byte;
         in_end_ff  <= req_bus.stream_end;
      end
      if (step_fire && step.has_result) begin
         out_cp_ff  <= step.code_point;
         out_err_ff <= step.error_code;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.code_point = out_cp_ff;
   assign rsp_bus.error_code = out_err_ff;

endmodule
